### rtl/sbpf_pkg.sv
// shared types, constants and crc function for the servo bus packet framer
`timescale 1ns / 1ps
package sbpf_pkg;

	// servo count range and field widths
	localparam int MAX_SERVOS     = 5;
	localparam int NUM_SERVOS_DEF = 5;
	localparam int SERVO_W        = 3;
	localparam int POS_W          = 12;
	localparam int HEAD_W         = 4;

	// op codes of a request
	localparam logic [1:0] OP_POS_SYNC  = 2'd0;
	localparam logic [1:0] OP_READ      = 2'd1;
	localparam logic [1:0] OP_BYTE_SYNC = 2'd2;
	localparam logic [1:0] OP_NONE      = 2'd3;

	// packet bytes
	localparam logic [7:0] ID_OFFSET_RST   = 8'd11;
	localparam logic [7:0] HDR_SYNC        = 8'hFF;
	localparam logic [7:0] HDR_FD          = 8'hFD;
	localparam logic [7:0] BCAST_ID        = 8'hFE;
	localparam logic [7:0] INST_SYNC_WRITE = 8'h83;
	localparam logic [7:0] INST_READ       = 8'h02;
	localparam logic [7:0] ADDR_GOAL       = 8'd116;
	localparam logic [7:0] LEN_READ        = 8'd7;
	localparam logic [7:0] DATA_LEN_WORD   = 8'd4;
	localparam logic [7:0] DATA_LEN_BYTE   = 8'd1;
	localparam logic [15:0] CRC_POLY       = 16'h8005;

	// last header step (bytes 0..11 before any per-servo data)
	localparam logic [HEAD_W-1:0] HEAD_LAST = 4'd11;
	// last per-servo field of each sync write
	localparam logic [2:0] POS_FIELD_LAST  = 3'd4;
	localparam logic [2:0] BYTE_FIELD_LAST = 3'd1;

	typedef enum logic [3:0] {
		SEL_SYNC,
		SEL_FD,
		SEL_ZERO,
		SEL_ID,
		SEL_LEN,
		SEL_INST,
		SEL_ADDR,
		SEL_DLEN,
		SEL_SERVO_ID,
		SEL_POS_LO,
		SEL_POS_HI,
		SEL_VALUE,
		SEL_CRC_LO,
		SEL_CRC_HI
	} byte_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_BODY,
		ST_CRC_LO,
		ST_CRC_HI
	} state_t;

	typedef struct packed {
		logic               start;
		logic               load;
		byte_sel_t          sel;
		logic [1:0]         kind;
		logic [SERVO_W-1:0] servo;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_stat_t;

	// crc-16, poly 0x8005, msb first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/sbpf_ctrl.sv
// packet sequencer state machine for the servo bus packet framer
`timescale 1ns / 1ps
module sbpf_ctrl #(
	parameter int NUM_SERVOS = sbpf_pkg::NUM_SERVOS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        op,
	output logic              in_ready,
	input  sbpf_pkg::dp_stat_t stat,
	output sbpf_pkg::dp_cmd_t  cmd
);

	localparam logic [sbpf_pkg::SERVO_W-1:0] LAST_SERVO = sbpf_pkg::SERVO_W'(NUM_SERVOS - 1);

	sbpf_pkg::state_t                 state_q, state_d;
	logic [sbpf_pkg::HEAD_W-1:0]      step_q, step_d;
	logic [sbpf_pkg::SERVO_W-1:0]     servo_q, servo_d;
	logic [2:0]                       field_q, field_d;
	logic [1:0]                       kind_q, kind_d;
	sbpf_pkg::byte_sel_t              head_sel, body_sel;
	logic                             last_field;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbpf_pkg::ST_IDLE;
			step_q  <= '0;
			servo_q <= '0;
			field_q <= '0;
			kind_q  <= sbpf_pkg::OP_POS_SYNC;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			servo_q <= servo_d;
			field_q <= field_d;
			kind_q  <= kind_d;
		end
	end

	// header byte order
	always_comb begin
		case (step_q)
			4'd0, 4'd1: head_sel = sbpf_pkg::SEL_SYNC;
			4'd2:       head_sel = sbpf_pkg::SEL_FD;
			4'd4:       head_sel = sbpf_pkg::SEL_ID;
			4'd5:       head_sel = sbpf_pkg::SEL_LEN;
			4'd7:       head_sel = sbpf_pkg::SEL_INST;
			4'd8:       head_sel = sbpf_pkg::SEL_ADDR;
			4'd10:      head_sel = sbpf_pkg::SEL_DLEN;
			default:    head_sel = sbpf_pkg::SEL_ZERO;
		endcase
	end

	// per-servo byte order
	always_comb begin
		case (field_q)
			3'd0:    body_sel = sbpf_pkg::SEL_SERVO_ID;
			3'd1:    body_sel = (kind_q == sbpf_pkg::OP_POS_SYNC) ? sbpf_pkg::SEL_POS_LO
			                                                    : sbpf_pkg::SEL_VALUE;
			3'd2:    body_sel = sbpf_pkg::SEL_POS_HI;
			default: body_sel = sbpf_pkg::SEL_ZERO;
		endcase
	end

	assign last_field = (kind_q == sbpf_pkg::OP_POS_SYNC) ?
	                    (field_q == sbpf_pkg::POS_FIELD_LAST) :
	                    (field_q == sbpf_pkg::BYTE_FIELD_LAST);

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		servo_d   = servo_q;
		field_d   = field_q;
		kind_d    = kind_q;
		in_ready  = 1'b0;
		cmd.start = 1'b0;
		cmd.load  = 1'b0;
		cmd.sel   = sbpf_pkg::SEL_ZERO;
		cmd.kind  = kind_q;
		cmd.servo = servo_q;
		case (state_q)
			sbpf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (op != sbpf_pkg::OP_NONE)) begin
					cmd.start = 1'b1;
					kind_d    = op;
					step_d    = '0;
					state_d   = sbpf_pkg::ST_HEAD;
				end
			end
			sbpf_pkg::ST_HEAD: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.sel  = head_sel;
					if (step_q == sbpf_pkg::HEAD_LAST) begin
						servo_d = '0;
						field_d = '0;
						state_d = (kind_q == sbpf_pkg::OP_READ) ? sbpf_pkg::ST_CRC_LO
						                                        : sbpf_pkg::ST_BODY;
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			sbpf_pkg::ST_BODY: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.sel  = body_sel;
					if (last_field) begin
						field_d = '0;
						if (servo_q == LAST_SERVO) begin
							state_d = sbpf_pkg::ST_CRC_LO;
						end else begin
							servo_d = servo_q + 1'b1;
						end
					end else begin
						field_d = field_q + 1'b1;
					end
				end
			end
			sbpf_pkg::ST_CRC_LO: begin
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.sel  = sbpf_pkg::SEL_CRC_LO;
					state_d  = sbpf_pkg::ST_CRC_HI;
				end
			end
			sbpf_pkg::ST_CRC_HI: begin
				// the next request may start while the final byte goes out
				in_ready = stat.slot_free;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.sel  = sbpf_pkg::SEL_CRC_HI;
					state_d  = sbpf_pkg::ST_IDLE;
					if (in_valid && (op != sbpf_pkg::OP_NONE)) begin
						cmd.start = 1'b1;
						kind_d    = op;
						step_d    = '0;
						state_d   = sbpf_pkg::ST_HEAD;
					end
				end
			end
			default: begin
				state_d = sbpf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/sbpf_dp.sv
// operand latches, byte select, crc and output register of the servo bus packet framer
`timescale 1ns / 1ps
module sbpf_dp #(
	parameter int NUM_SERVOS = sbpf_pkg::NUM_SERVOS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [7:0]                cfg_data,
	input  sbpf_pkg::dp_cmd_t         cmd,
	output sbpf_pkg::dp_stat_t        stat,
	input  logic [sbpf_pkg::POS_W-1:0] pos_in [sbpf_pkg::MAX_SERVOS],
	input  logic [2:0]                servo_index,
	input  logic [7:0]                reg_address,
	input  logic [7:0]                byte_value,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [7:0]                out_byte,
	output logic                      last_byte
);

	localparam int         SRV_IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam logic [7:0] LEN_POS   = 8'(7 + 5 * NUM_SERVOS);
	localparam logic [7:0] LEN_BYTE  = 8'(7 + 2 * NUM_SERVOS);

	logic [7:0]                 id_offset_q;
	logic [15:0]                crc_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;
	logic [sbpf_pkg::POS_W-1:0] pos_q [NUM_SERVOS];
	logic [7:0]                 addr_q;
	logic [7:0]                 value_q;
	logic [2:0]                 servo_q;
	logic [sbpf_pkg::POS_W-1:0] pos_cur;
	logic [7:0]                 next_byte;
	logic                       slot_free;

	assign slot_free      = !out_valid_q || out_ready;
	assign stat.slot_free = slot_free;
	assign pos_cur        = pos_q[cmd.servo[SRV_IDX_W-1:0]];

	always_comb begin
		case (cmd.sel)
			sbpf_pkg::SEL_SYNC:     next_byte = sbpf_pkg::HDR_SYNC;
			sbpf_pkg::SEL_FD:       next_byte = sbpf_pkg::HDR_FD;
			sbpf_pkg::SEL_ID:       next_byte = (cmd.kind == sbpf_pkg::OP_READ) ?
			                                    (8'(servo_q) + id_offset_q) : sbpf_pkg::BCAST_ID;
			sbpf_pkg::SEL_LEN: begin
				case (cmd.kind)
					sbpf_pkg::OP_POS_SYNC: next_byte = LEN_POS;
					sbpf_pkg::OP_READ:     next_byte = sbpf_pkg::LEN_READ;
					default:               next_byte = LEN_BYTE;
				endcase
			end
			sbpf_pkg::SEL_INST:     next_byte = (cmd.kind == sbpf_pkg::OP_READ) ?
			                                    sbpf_pkg::INST_READ : sbpf_pkg::INST_SYNC_WRITE;
			sbpf_pkg::SEL_ADDR:     next_byte = (cmd.kind == sbpf_pkg::OP_POS_SYNC) ?
			                                    sbpf_pkg::ADDR_GOAL : addr_q;
			sbpf_pkg::SEL_DLEN:     next_byte = (cmd.kind == sbpf_pkg::OP_BYTE_SYNC) ?
			                                    sbpf_pkg::DATA_LEN_BYTE : sbpf_pkg::DATA_LEN_WORD;
			sbpf_pkg::SEL_SERVO_ID: next_byte = 8'(cmd.servo) + id_offset_q;
			sbpf_pkg::SEL_POS_LO:   next_byte = pos_cur[7:0];
			sbpf_pkg::SEL_POS_HI:   next_byte = 8'(pos_cur[sbpf_pkg::POS_W-1:8]);
			sbpf_pkg::SEL_VALUE:    next_byte = value_q;
			sbpf_pkg::SEL_CRC_LO:   next_byte = crc_q[7:0];
			sbpf_pkg::SEL_CRC_HI:   next_byte = crc_q[15:8];
			default:                next_byte = 8'h00;
		endcase
	end

	// config register, crc and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_offset_q <= sbpf_pkg::ID_OFFSET_RST;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				id_offset_q <= cfg_data;
			end
			if (cmd.start) begin
				crc_q <= '0;
			end else if (cmd.load && (cmd.sel != sbpf_pkg::SEL_CRC_LO) &&
			             (cmd.sel != sbpf_pkg::SEL_CRC_HI)) begin
				crc_q <= sbpf_pkg::crc_byte(crc_q, next_byte);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= next_byte;
			last_q     <= (cmd.sel == sbpf_pkg::SEL_CRC_HI);
		end
		if (cmd.start) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				pos_q[i] <= pos_in[i];
			end
			addr_q  <= reg_address;
			value_q <= byte_value;
			servo_q <= servo_index;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

### rtl/servo_bus_packet_framer.sv
// servo bus protocol-2 packet framer, top level
//
// in channel (in_valid/in_ready): one request per packet; op selects a goal
//   position sync write (op 0), a four-byte read request (op 1) or a one-byte
//   sync write of byte_value to every servo (op 2). op 3 is taken and dropped.
// out channel (out_valid/out_ready): the packet, one byte per transfer, with
//   last_byte set on the crc high byte that closes it.
// cfg channel (cfg_valid/cfg_ready): writes id_offset, always ready; write it
//   only between packets.
// packet sizes: op 0 is 14 + 5*NUM_SERVOS bytes, op 1 is 14, op 2 is
//   14 + 2*NUM_SERVOS. crc-16 (poly 0x8005, init 0) trails, low byte first.
// the first header byte is loaded in the header state that follows the request.
// throughput: one byte per cycle from the output register while out_ready
//   holds high; the next request is taken in the cycle the crc high byte is
//   loaded, so back-to-back packets follow with no gap.
// the sequencer holds in_ready low while it walks a packet; a stalled receiver
//   simply freezes the sequencer, and the held byte stays on out.
// reset (arst_n low) drops any packet in flight, clears out_valid (out_byte
//   and last_byte are not reset) and sets id_offset back to 11.
`timescale 1ns / 1ps
module servo_bus_packet_framer #(
	parameter int NUM_SERVOS = sbpf_pkg::NUM_SERVOS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// requests
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] position_0,
	input  logic [11:0] position_1,
	input  logic [11:0] position_2,
	input  logic [11:0] position_3,
	input  logic [11:0] position_4,
	input  logic [2:0]  servo_index,
	input  logic [7:0]  reg_address,
	input  logic [7:0]  byte_value,
	// packet bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	sbpf_pkg::dp_cmd_t          cmd;
	sbpf_pkg::dp_stat_t         stat;
	logic [sbpf_pkg::POS_W-1:0] pos_in [sbpf_pkg::MAX_SERVOS];

	// id_offset is a plain register, never busy
	assign cfg_ready = 1'b1;

	assign pos_in[0] = position_0;
	assign pos_in[1] = position_1;
	assign pos_in[2] = position_2;
	assign pos_in[3] = position_3;
	assign pos_in[4] = position_4;

	// sequencer: walks header, per-servo data (sync writes only) and crc
	sbpf_ctrl #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: operand latches, byte mux, crc and output register
	sbpf_dp #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.pos_in      (pos_in),
		.servo_index (servo_index),
		.reg_address (reg_address),
		.byte_value  (byte_value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

endmodule

### rtl/sbpf_checker.sv
// port-level checks for the servo bus packet framer, bound to the top level
`timescale 1ns / 1ps
module sbpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  op,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last_byte
);

	// a stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("stalled output byte changed");

	// a taken packet request is followed by in_ready low
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op != sbpf_pkg::OP_NONE) |=> !in_ready)
		else $error("request taken while a packet was starting");

	// in_ready only drops after a request was taken
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready dropped without a request");

	// a packet end is never followed right away by another end
	a_no_short_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !(out_valid && last_byte))
		else $error("packet shorter than two bytes");

endmodule

bind servo_bus_packet_framer sbpf_checker u_sbpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last_byte (last_byte)
);
